FILE: rtl/core/page_table_first_touch_mapper_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the page table mapper
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef PAGE_TABLE_FIRST_TOUCH_MAPPER_TOP_ASSERT_SVH
`define PAGE_TABLE_FIRST_TOUCH_MAPPER_TOP_ASSERT_SVH

// same-cycle implication
`define PTFM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ptfm_pkg.sv
// ---------------------------------------------------------------------------
// ptfm_pkg
// Types, constants and helpers shared by the page table mapper modules.
// ---------------------------------------------------------------------------
package ptfm_pkg;

  localparam int PROCESSES_DEF  = 3;
  localparam int ENTRIES_DEF    = 256;
  localparam int PAGE_SHIFT     = 12;
  localparam int PAGE_W         = 20;
  localparam int FRAME_W        = 20;
  localparam int FRAMES_W       = 21;
  localparam int CNT_W          = 32;
  localparam int PID_W          = 2;
  localparam int VADDR_W        = 32;
  localparam int OUT_DATA_W     = 152;

  // frames_left never exceeds the size of the 20-bit frame space
  localparam logic [FRAMES_W-1:0] MAX_FRAMES = 21'h10_0000;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_ALLOC = 2'd1,
    OUT_FAULT = 2'd2,
    OUT_FULL  = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // one page table entry as held in the table memory
  typedef struct packed {
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } entry_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

FILE: rtl/core/ptfm_table.sv
// ---------------------------------------------------------------------------
// ptfm_table
// Page table memory: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module ptfm_table #(
  parameter int DEPTH  = ptfm_pkg::PROCESSES_DEF * ptfm_pkg::ENTRIES_DEF,
  parameter int ADDR_W = $clog2(ptfm_pkg::PROCESSES_DEF * ptfm_pkg::ENTRIES_DEF)
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output ptfm_pkg::entry_t    rd_data,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  ptfm_pkg::entry_t    wr_data
);
  import ptfm_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/page_table_first_touch_mapper_top.sv
// ---------------------------------------------------------------------------
// page_table_first_touch_mapper_top
// Per-process linear page tables with a bump frame allocator and counters.
// ---------------------------------------------------------------------------
// Channel  Dir  Fields (low bit up)
// in_      in   tuser: process_id[1:0]; tdata: virtual_address[31:0]
// out_     out  tuser: outcome[1:0]; tdata: frame_number[19:0], hits[51:20],
//               allocations[83:52], faults[115:84], accesses[147:116]
// cfg_     in   wr_data: free_frames_initial[20:0]
//
// One access is handled at a time. An access scans its process table
// through the table memory, one entry per cycle, through the single read
// port and its registered read data. A hit ends the scan.
// Reset is synchronous; no clearing pass, tables are empty by fill count.
// A stalled result sits in the output register while the next access is
// taken; that access finishes only once the register is free.
// ---------------------------------------------------------------------------
`include "page_table_first_touch_mapper_top_assert.svh"

module page_table_first_touch_mapper_top #(
  parameter int PROCESSES           = ptfm_pkg::PROCESSES_DEF,
  parameter int ENTRIES_PER_PROCESS = ptfm_pkg::ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // process_id[1:0]
  input  logic [ptfm_pkg::PID_W-1:0]          in_tuser,
  // virtual_address[31:0]
  input  logic [ptfm_pkg::VADDR_W-1:0]        in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // outcome[1:0]
  output logic [1:0]                          out_tuser,
  // frame_number[19:0], hits_so_far[51:20], allocations_so_far[83:52],
  // faults_so_far[115:84], accesses_so_far[147:116], zero[151:148]
  output logic [ptfm_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_wr_en,
  input  logic [ptfm_pkg::FRAMES_W-1:0]       cfg_wr_data
);
  import ptfm_pkg::*;

  localparam int DEPTH    = PROCESSES * ENTRIES_PER_PROCESS;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int USED_W   = $clog2(ENTRIES_PER_PROCESS + 1);
  localparam logic [USED_W-1:0] USED_FULL = USED_W'(ENTRIES_PER_PROCESS);
  localparam logic [ADDR_W-1:0] ROW_SIZE  = ADDR_W'(ENTRIES_PER_PROCESS);

  // control state
  state_t               state_r, state_nxt;
  logic [PID_W-1:0]     pid_r;
  logic [PAGE_W-1:0]    vpn_r;
  logic                 oor_r;
  logic [USED_W-1:0]    used_r;
  logic [USED_W-1:0]    issue_idx_r, issue_idx_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [USED_W-1:0]    entries_used_r [PROCESSES];
  logic [FRAMES_W-1:0]  next_frame_r;
  logic [FRAMES_W-1:0]  frames_left_r;
  logic [CNT_W-1:0]     hit_total_r, alloc_total_r, fault_total_r, access_total_r;
  outcome_t             res_outcome_r;
  logic [FRAME_W-1:0]   res_frame_r;
  logic                 out_tvalid_r;
  logic [1:0]           out_tuser_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic                 in_xfer, out_free;
  logic [USED_W-1:0]    used_sel;
  logic                 hit_now, miss_now, decide, do_alloc;
  outcome_t             dec_outcome;
  logic [FRAME_W-1:0]   dec_frame;
  logic                 issue;
  logic [ADDR_W-1:0]    row_base;
  entry_t               rd_data, wr_data;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  // fill count of the requested process; out-of-range reads as empty
  always_comb begin
    used_sel = '0;
    for (int p = 0; p < PROCESSES; p++) begin
      if (int'(in_tuser) == p) used_sel = entries_used_r[p];
    end
  end

  // scan compare and the final decision
  assign row_base = ADDR_W'(pid_r) * ROW_SIZE;
  assign hit_now  = (state_r == ST_SCAN) && rd_vld_r && !oor_r && (rd_data.page == vpn_r);
  assign miss_now = (state_r == ST_SCAN) && !rd_vld_r && (issue_idx_r == used_r);
  assign decide   = hit_now || miss_now;
  assign issue    = (state_r == ST_SCAN) && !hit_now && (issue_idx_r != used_r);

  always_comb begin
    dec_outcome = OUT_FULL;
    dec_frame   = '0;
    do_alloc    = 1'b0;
    if (oor_r) begin
      dec_outcome = OUT_FULL;
    end else if (hit_now) begin
      dec_outcome = OUT_HIT;
      dec_frame   = rd_data.frame;
    end else if (frames_left_r == '0) begin
      dec_outcome = OUT_FAULT;
    end else if (used_r >= USED_FULL) begin
      dec_outcome = OUT_FULL;
    end else begin
      dec_outcome = OUT_ALLOC;
      dec_frame   = next_frame_r[FRAME_W-1:0];
      do_alloc    = miss_now;
    end
  end

  // next state and scan pointer
  always_comb begin
    state_nxt     = state_r;
    issue_idx_nxt = issue_idx_r;
    rd_vld_nxt    = issue;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt     = ST_SCAN;
          issue_idx_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (decide) begin
          state_nxt = ST_FINISH;
        end else if (issue) begin
          issue_idx_nxt = issue_idx_r + 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issue_idx_r <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_idx_r <= issue_idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
    end
  end

  // access capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pid_r  <= in_tuser;
      vpn_r  <= in_tdata[VADDR_W-1:PAGE_SHIFT];
      oor_r  <= (int'(in_tuser) >= PROCESSES);
      used_r <= used_sel;
    end
  end

  // fill counts, allocator and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PROCESSES; p++) entries_used_r[p] <= '0;
      next_frame_r   <= '0;
      frames_left_r  <= '0;
      hit_total_r    <= '0;
      alloc_total_r  <= '0;
      fault_total_r  <= '0;
      access_total_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        frames_left_r <= (cfg_wr_data > MAX_FRAMES) ? MAX_FRAMES : cfg_wr_data;
      end else if (do_alloc) begin
        frames_left_r <= frames_left_r - 1'b1;
      end
      if (decide) begin
        access_total_r <= sat_inc(access_total_r);
        if (dec_outcome == OUT_HIT)   hit_total_r   <= sat_inc(hit_total_r);
        if (dec_outcome == OUT_FAULT) fault_total_r <= sat_inc(fault_total_r);
      end
      if (do_alloc) begin
        alloc_total_r <= sat_inc(alloc_total_r);
        next_frame_r  <= next_frame_r + 1'b1;
        for (int p = 0; p < PROCESSES; p++) begin
          if (int'(pid_r) == p) entries_used_r[p] <= used_r + 1'b1;
        end
      end
    end
  end

  // held result of the decision
  always_ff @(posedge clk) begin
    if (decide) begin
      res_outcome_r <= dec_outcome;
      res_frame_r   <= dec_frame;
    end
  end

  // table memory
  assign wr_data.page  = vpn_r;
  assign wr_data.frame = next_frame_r[FRAME_W-1:0];

  ptfm_table #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk     (clk),
    .rd_en   (issue),
    .rd_addr (row_base + ADDR_W'(issue_idx_r)),
    .rd_data (rd_data),
    .wr_en   (do_alloc),
    .wr_addr (row_base + ADDR_W'(used_r)),
    .wr_data (wr_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == ST_FINISH && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FINISH && out_free) begin
      out_tuser_r <= res_outcome_r;
      out_tdata_r <= {4'b0, access_total_r, fault_total_r, alloc_total_r,
                      hit_total_r, res_frame_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = out_tdata_r;

  // checks
  `PTFM_ASSERT_NEXT(a_one_at_a_time, in_xfer, !in_tready,
    "new access taken while one is in progress")
  `PTFM_ASSERT_SAME(a_no_frame_on_miss,
    out_tvalid && (out_tuser == OUT_FAULT || out_tuser == OUT_FULL),
    out_tdata[FRAME_W-1:0] == '0, "nonzero frame on fault or full table")
  `PTFM_ASSERT_SAME(a_frames_bound, 1'b1, frames_left_r <= MAX_FRAMES,
    "free frame count above frame space")
  `PTFM_ASSERT_SAME(a_alloc_has_frames, do_alloc, frames_left_r != '0 && !oor_r,
    "allocation without a free frame")

endmodule

FILE: verif/page_table_first_touch_mapper_top_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// page_table_first_touch_mapper_top_tb
// Self-checking bench for the per-process page table mapper. A directed
// table covers reset state, both address extremes, out-of-range process,
// fault and full-table outcomes and frame pool saturation; random phases
// then fill tables, exhaust the frame pool and mix hits with fresh pages
// under sender gaps, receiver stalls and one long output hold-off. Every
// result is checked against an in-bench translation model.
// ---------------------------------------------------------------------------
module page_table_first_touch_mapper_top_tb;
  import ptfm_pkg::*;

  localparam int PROCS   = PROCESSES_DEF;
  localparam int ENTRIES = ENTRIES_DEF;

  // one translation result as seen on the out_ channel
  typedef struct {
    outcome_t           outcome;
    logic [FRAME_W-1:0] frame;
    logic [CNT_W-1:0]   hits;
    logic [CNT_W-1:0]   allocs;
    logic [CNT_W-1:0]   faults;
    logic [CNT_W-1:0]   accesses;
  } xlat_result_t;

  typedef enum logic {ROW_ACCESS, ROW_CONFIG} row_kind_t;
  typedef enum int {PIDS_ZERO, PIDS_UPPER, PIDS_ANY} pid_mix_t;

  // directed row; value is the address, or the register value for config
  typedef struct {
    row_kind_t          kind;
    logic [PID_W-1:0]   pid;
    logic [31:0]        value;
    bit                 typed;
    outcome_t           outcome;
    logic [FRAME_W-1:0] frame;
  } dir_row_t;

  localparam int DIR_ROWS = 23;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_ACCESS, 2'd0, 32'h0000_0000, 1'b1, OUT_FAULT, 20'd0},
    '{ROW_ACCESS, 2'd3, 32'hFFFF_FFFF, 1'b1, OUT_FULL,  20'd0},
    '{ROW_ACCESS, 2'd2, 32'hFFFF_F000, 1'b1, OUT_FAULT, 20'd0},
    '{ROW_CONFIG, 2'd0, 32'd3,         1'b0, OUT_HIT,   20'd0},
    '{ROW_ACCESS, 2'd0, 32'h0000_0FFF, 1'b1, OUT_ALLOC, 20'd0},
    '{ROW_ACCESS, 2'd0, 32'h0000_0000, 1'b0, OUT_HIT,   20'd0},
    '{ROW_ACCESS, 2'd1, 32'hFFFF_FFFF, 1'b1, OUT_ALLOC, 20'd1},
    '{ROW_ACCESS, 2'd2, 32'hFFFF_F000, 1'b0, OUT_HIT,   20'd0},
    '{ROW_ACCESS, 2'd1, 32'hFFFF_F123, 1'b0, OUT_HIT,   20'd0},
    '{ROW_ACCESS, 2'd0, 32'h1234_5678, 1'b1, OUT_FAULT, 20'd0},
    '{ROW_ACCESS, 2'd3, 32'h0000_0000, 1'b1, OUT_FULL,  20'd0},
    '{ROW_ACCESS, 2'd0, 32'h0000_0000, 1'b0, OUT_HIT,   20'd0},
    '{ROW_CONFIG, 2'd0, 32'h001F_FFFF, 1'b0, OUT_HIT,   20'd0},
    '{ROW_ACCESS, 2'd0, 32'h1234_5678, 1'b0, OUT_HIT,   20'd0},
    '{ROW_ACCESS, 2'd2, 32'hAAAA_A555, 1'b0, OUT_HIT,   20'd0},
    '{ROW_ACCESS, 2'd1, 32'h5555_5AAA, 1'b0, OUT_HIT,   20'd0},
    '{ROW_ACCESS, 2'd2, 32'hFFFF_F000, 1'b0, OUT_HIT,   20'd0},
    '{ROW_ACCESS, 2'd2, 32'hAAAA_AFFF, 1'b0, OUT_HIT,   20'd0},
    '{ROW_ACCESS, 2'd0, 32'h0000_1000, 1'b0, OUT_HIT,   20'd0},
    '{ROW_CONFIG, 2'd0, 32'h0010_0000, 1'b0, OUT_HIT,   20'd0},
    '{ROW_ACCESS, 2'd0, 32'h1234_5000, 1'b0, OUT_HIT,   20'd0},
    '{ROW_ACCESS, 2'd3, 32'h8000_0000, 1'b1, OUT_FULL,  20'd0},
    '{ROW_ACCESS, 2'd1, 32'h0000_0000, 1'b0, OUT_HIT,   20'd0}
  };

  logic                  clk;
  logic                  rst_n;
  logic [PID_W-1:0]      in_tuser;
  logic [VADDR_W-1:0]    in_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [1:0]            out_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_wr_en;
  logic [FRAMES_W-1:0]   cfg_wr_data;

  // translation model state
  logic [PAGE_W-1:0]   pt_page  [PROCS][ENTRIES];
  logic [FRAME_W-1:0]  pt_frame [PROCS][ENTRIES];
  int                  pt_count [PROCS];
  logic [FRAMES_W-1:0] next_frame;
  logic [FRAMES_W-1:0] frames_left;
  logic [CNT_W-1:0]    hit_cnt;
  logic [CNT_W-1:0]    alloc_cnt;
  logic [CNT_W-1:0]    fault_cnt;
  logic [CNT_W-1:0]    access_cnt;

  xlat_result_t pending_xlat_q [$];

  int idle_pct;
  int stall_pct;
  int hold_request;
  int hold_left;
  int mismatch_count;

  page_table_first_touch_mapper_top #(
    .PROCESSES           (PROCS),
    .ENTRIES_PER_PROCESS (ENTRIES)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tuser   (out_tuser),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // saturating counter step
  function automatic logic [CNT_W-1:0] count_up(logic [CNT_W-1:0] v);
    return v + {{(CNT_W-1){1'b0}}, ~&v};
  endfunction

  // translate one access and advance the model
  function automatic xlat_result_t translate_access(logic [PID_W-1:0] pid,
                                                    logic [VADDR_W-1:0] addr);
    xlat_result_t      r;
    logic [PAGE_W-1:0] page;
    int                hit_idx;
    int                used;
    page       = addr[VADDR_W-1:PAGE_SHIFT];
    r.frame    = '0;
    access_cnt = count_up(access_cnt);
    if (pid >= PROCS) begin
      r.outcome = OUT_FULL;
    end else begin
      used    = pt_count[pid];
      hit_idx = -1;
      for (int i = 0; i < used; i++) begin
        if (hit_idx < 0 && pt_page[pid][i] == page) hit_idx = i;
      end
      if (hit_idx >= 0) begin
        r.outcome = OUT_HIT;
        r.frame   = pt_frame[pid][hit_idx];
        hit_cnt   = count_up(hit_cnt);
      end else if (frames_left == '0) begin
        r.outcome = OUT_FAULT;
        fault_cnt = count_up(fault_cnt);
      end else if (used >= ENTRIES) begin
        r.outcome = OUT_FULL;
      end else begin
        r.outcome            = OUT_ALLOC;
        r.frame              = next_frame[FRAME_W-1:0];
        pt_page[pid][used]   = page;
        pt_frame[pid][used]  = r.frame;
        pt_count[pid]        = used + 1;
        next_frame           = next_frame + 1'b1;
        frames_left          = frames_left - 1'b1;
        alloc_cnt            = count_up(alloc_cnt);
      end
    end
    r.hits     = hit_cnt;
    r.allocs   = alloc_cnt;
    r.faults   = fault_cnt;
    r.accesses = access_cnt;
    return r;
  endfunction

  // address generator: reuse a mapped page of the process or go random
  function automatic logic [VADDR_W-1:0] pick_address(logic [PID_W-1:0] pid,
                                                      int reuse_pct);
    logic [VADDR_W-1:0] addr;
    addr = $urandom;
    if (pid < PROCS && pt_count[pid] > 0 && $urandom_range(99) < reuse_pct)
      addr[VADDR_W-1:PAGE_SHIFT] = pt_page[pid][$urandom_range(pt_count[pid] - 1)];
    return addr;
  endfunction

  task automatic log_mismatch(string field, logic [CNT_W-1:0] want,
                              logic [CNT_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t mismatch %s: expected %0h actual %0h", $realtime, field, want, got);
  endtask

  // one input transfer; expectation is recorded after the edge at which in_tready reads high
  task automatic send_access(logic [PID_W-1:0] pid, logic [VADDR_W-1:0] addr,
                             bit typed, outcome_t want_outcome,
                             logic [FRAME_W-1:0] want_frame);
    xlat_result_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= pid;
    in_tdata  <= addr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = translate_access(pid, addr);
    if (typed) begin
      r.outcome = want_outcome;
      r.frame   = want_frame;
    end
    pending_xlat_q.push_back(r);
  endtask

  // stop offering and wait until every result has been taken
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_xlat_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_free_frames(logic [FRAMES_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    frames_left  = (value > MAX_FRAMES) ? MAX_FRAMES : value;
  endtask

  task automatic run_random(int count, pid_mix_t mix, int reuse_pct);
    logic [PID_W-1:0] pid;
    for (int n = 0; n < count; n++) begin
      case (mix)
        PIDS_ZERO:  pid = 2'd0;
        PIDS_UPPER: pid = ($urandom_range(99) < 10) ? 2'd3 : 2'($urandom_range(2, 1));
        default:    pid = ($urandom_range(99) < 10) ? 2'd3 : 2'($urandom_range(2));
      endcase
      send_access(pid, pick_address(pid, reuse_pct), 1'b0, OUT_HIT, '0);
    end
  endtask

  // result side: check each transfer, then pick next ready level
  initial begin
    xlat_result_t want;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (pending_xlat_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t unexpected result: expected none actual outcome %0d",
                     $realtime, out_tuser);
        end else begin
          want = pending_xlat_q.pop_front();
          if (out_tuser != want.outcome)
            log_mismatch("outcome", CNT_W'(want.outcome), CNT_W'(out_tuser));
          if (out_tdata[19:0] != want.frame)
            log_mismatch("frame_number", CNT_W'(want.frame), CNT_W'(out_tdata[19:0]));
          if (out_tdata[51:20] != want.hits)
            log_mismatch("hits_so_far", want.hits, out_tdata[51:20]);
          if (out_tdata[83:52] != want.allocs)
            log_mismatch("allocations_so_far", want.allocs, out_tdata[83:52]);
          if (out_tdata[115:84] != want.faults)
            log_mismatch("faults_so_far", want.faults, out_tdata[115:84]);
          if (out_tdata[147:116] != want.accesses)
            log_mismatch("accesses_so_far", want.accesses, out_tdata[147:116]);
          if (out_tdata[151:148] != 4'd0)
            log_mismatch("tdata pad", '0, CNT_W'(out_tdata[151:148]));
        end
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
        out_tready  <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // main sequence
  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tuser       = '0;
    in_tdata       = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    idle_pct       = 0;
    stall_pct      = 0;
    hold_request   = 0;
    hold_left      = 0;
    mismatch_count = 0;
    for (int p = 0; p < PROCS; p++) pt_count[p] = 0;
    next_frame  = '0;
    frames_left = '0;
    hit_cnt     = '0;
    alloc_cnt   = '0;
    fault_cnt   = '0;
    access_cnt  = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int k = 0; k < DIR_ROWS; k++) begin
      if (dir_rows[k].kind == ROW_CONFIG) begin
        wait_idle();
        write_free_frames(dir_rows[k].value[FRAMES_W-1:0]);
      end else begin
        send_access(dir_rows[k].pid, dir_rows[k].value, dir_rows[k].typed,
                    dir_rows[k].outcome, dir_rows[k].frame);
      end
    end

    // fill process 0 past its table size, back to back
    run_random(380, PIDS_ZERO, 25);

    // empty pool on a full table: misses fault, hits still map
    wait_idle();
    write_free_frames('0);
    run_random(40, PIDS_ZERO, 50);

    // small pool, sender gaps
    wait_idle();
    write_free_frames(FRAMES_W'($urandom_range(200, 20)));
    idle_pct = 58;
    run_random(230, PIDS_UPPER, 50);

    // widest register value, receiver stalls and one long hold-off
    wait_idle();
    write_free_frames('1);
    idle_pct     = 0;
    stall_pct    = 58;
    hold_request = 800;
    run_random(230, PIDS_ANY, 50);

    // any register value, both sides idle
    wait_idle();
    write_free_frames(FRAMES_W'($urandom_range(21'h1F_FFFF)));
    idle_pct  = 22;
    stall_pct = 22;
    run_random(230, PIDS_ANY, 60);

    // drain
    stall_pct = 0;
    wait_idle();
    repeat (ENTRIES + 40) @(posedge clk);
    if (pending_xlat_q.size() != 0) mismatch_count++;

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
